FILE: sv/fdc_pkg.sv
// Package for the frame deframer with CRC-32 check: result types, codes,
// constants and the byte-wise CRC-32 update function. No dependencies.
`default_nettype none

package fdc_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int HEADER_BYTES_DEF = 14;
  localparam int MAX_FRAME_DEF    = 2048;

  // Trailing frame check field length in bytes.
  localparam int FCS_BYTES = 4;

  // Reflected CRC-32.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Result word kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame status codes.
  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_SHORT    = 2'd2;

  // Result queue depth and pointer widths.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       kind;
    logic [7:0] out_data;
    logic [1:0] status;
    logic       is_last;
  } result_t;

  // Up to two result words pushed per processed byte; first goes in first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // One byte of reflected CRC-32, bit-serial form unrolled over eight steps.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return (crc >> 8) ^ c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fdc_if.sv
// Valid/ready channel interfaces for received bytes and for result words.
// Depends on nothing.
`default_nettype none

interface fdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_end;

  modport source (output valid, output in_byte, output frame_end, input ready);
  modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

interface fdc_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_data;
  logic [1:0] status;
  logic       is_last;

  modport source (output valid, output kind, output out_data, output status,
                  output is_last, input ready);
  modport sink   (input valid, input kind, input out_data, input status,
                  input is_last, output ready);
endinterface

`default_nettype wire

FILE: sv/fdc_result_queue.sv
// Small result queue: takes up to two result words a cycle, hands one out
// a cycle while result.ready is high. Depends on fdc_pkg and fdc_if.
`default_nettype none

module fdc_result_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire fdc_pkg::push_t push,
  output logic                room2,
  fdc_result_if.source        result
);
  import fdc_pkg::*;

  result_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic [QCNT_W-1:0]  fill_next;
  logic               pop;
  logic [QPTR_W-1:0]  wr_ptr_plus1;

  // Head of the queue drives the channel.
  assign result.valid    = (fill != '0);
  assign result.kind     = entries[rd_ptr].kind;
  assign result.out_data = entries[rd_ptr].out_data;
  assign result.status   = entries[rd_ptr].status;
  assign result.is_last  = entries[rd_ptr].is_last;

  assign pop          = result.valid && result.ready;
  assign wr_ptr_plus1 = wr_ptr + QPTR_W'(1);
  assign room2        = (fill <= QCNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    fill_next = fill + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      fill <= fill_next;
    end
  end

  // Storage; the second word lands right after the first.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.second;
    end
  end

endmodule

`default_nettype wire

FILE: sv/frame_deframer_crc32_check_unit.sv
// Top level of the frame deframer with CRC-32 frame check.
// Depends on fdc_pkg, fdc_if and fdc_result_queue.
//
//   channel  dir  fields                               word
//   rx       in   in_byte[7:0], frame_end              one received byte
//   result   out  kind, out_data[7:0], status[1:0],    one payload byte or
//                 is_last                              one frame status
//
// One byte is taken per cycle while rx.ready is high. A byte is held in the
// input register, then the CRC update, delay line shift and judging happen
// and the results are registered in a four-word queue. The last byte of a
// frame can make two words, which the queue drains at one per cycle while
// result.ready is high. rx.ready drops only while the queue lacks room for
// two words. Reset clears all control state.
`default_nettype none

module frame_deframer_crc32_check_unit #(
  parameter int HEADER_BYTES = fdc_pkg::HEADER_BYTES_DEF,
  parameter int MAX_FRAME    = fdc_pkg::MAX_FRAME_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  fdc_byte_if.sink     rx,
  fdc_result_if.source result
);
  import fdc_pkg::*;

  localparam int                  CountW   = $clog2(MAX_FRAME);
  localparam logic [CountW-1:0]   CountMax = CountW'(MAX_FRAME - 1);
  localparam logic [CountW-1:0]   FcsCount = CountW'(FCS_BYTES);
  localparam logic [CountW:0]     JudgeMin = (CountW + 1)'(HEADER_BYTES + FCS_BYTES);

  // Input register.
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_end;
  logic        fire;
  logic        room2;

  // Frame state.
  logic [31:0]       crc;
  logic [31:0]       crc_next;
  logic [7:0]        hold [FCS_BYTES];
  logic [CountW-1:0] byte_count;
  logic [CountW-1:0] byte_count_next;
  logic              feeds_crc;
  logic              is_payload;
  logic              is_short;
  logic [31:0]       sent;
  logic [1:0]        frame_status;
  result_t           payload_word;
  result_t           status_word;
  push_t             push;

  assign fire     = s1_valid && room2;
  assign rx.ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.in_byte;
      s1_end  <= rx.frame_end;
    end
  end

  // Per-byte work: CRC update on the leaving byte, payload and judging.
  always_comb begin
    feeds_crc       = (byte_count >= FcsCount);
    is_payload      = ({1'b0, byte_count} >= JudgeMin);
    crc_next        = feeds_crc ? crc32_byte(crc, hold[0]) : crc;
    byte_count_next = (byte_count < CountMax) ? byte_count + CountW'(1) : byte_count;
    is_short        = ({1'b0, byte_count_next} < JudgeMin);
    // Check field after the shift, least significant byte first.
    sent            = {s1_byte, hold[3], hold[2], hold[1]};
    if (is_short) begin
      frame_status = STATUS_SHORT;
    end else if (sent == crc_next) begin
      frame_status = STATUS_GOOD;
    end else begin
      frame_status = STATUS_MISMATCH;
    end

    payload_word = '{kind: KIND_PAYLOAD, out_data: hold[0], status: STATUS_GOOD,
                     is_last: 1'b0};
    status_word  = '{kind: KIND_STATUS, out_data: 8'd0, status: frame_status,
                     is_last: 1'b1};

    push.first  = is_payload ? payload_word : status_word;
    push.second = status_word;
    if (!fire) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'(is_payload) + 2'(s1_end);
    end
  end

  // Frame state registers; the last byte returns them to the start values.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= CRC_INIT;
      byte_count <= '0;
    end else if (fire) begin
      if (s1_end) begin
        crc        <= CRC_INIT;
        byte_count <= '0;
      end else begin
        crc        <= crc_next;
        byte_count <= byte_count_next;
      end
    end
  end

  // Delay line holding back the check field; entry 0 is the oldest byte.
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < FCS_BYTES - 1; i++) begin
        hold[i] <= hold[i + 1];
      end
      hold[FCS_BYTES - 1] <= s1_byte;
    end
  end

  fdc_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room2  (room2),
    .result (result)
  );

endmodule

`default_nettype wire

FILE: dv/fdc_tb_pkg.sv
`timescale 1ns / 100ps
// Verification helpers for the frame deframer: the reflected CRC-32 byte update
// used to build check fields and to predict frame status. Depends on fdc_pkg.
package fdc_tb_pkg;

  // Shift one byte into a reflected CRC-32, least significant bit first.
  function automatic logic [31:0] fcs_crc_update(input logic [31:0] crc,
                                                 input logic [7:0] b);
    logic [31:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ fdc_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

endpackage

FILE: dv/frame_deframer_crc32_check_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the frame deframer: watches the byte and result channels, predicts
// payload and status words and compares them. Depends on fdc_pkg, fdc_tb_pkg, fdc_if.
module frame_deframer_crc32_check_unit_checker #(
  parameter int HEADER_BYTES = fdc_pkg::HEADER_BYTES_DEF,
  parameter int MAX_FRAME    = fdc_pkg::MAX_FRAME_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  fdc_byte_if       rx,
  fdc_result_if     result,
  output int        errors,
  output int        words_due
);
  import fdc_pkg::*;

  result_t     due_q[$];
  logic [31:0] run_crc;
  logic [7:0]  held [0:3];
  int          frame_len;
  int          err_count = 0;

  initial begin
    errors    = 0;
    words_due = 0;
  end

  // Return the frame tracking state to its idle values.
  task automatic clear_frame();
    run_crc   = CRC_INIT;
    frame_len = 0;
    for (int i = 0; i < 4; i++) begin
      held[i] = 8'h00;
    end
  endtask

  // Predict the words that one accepted byte causes.
  task automatic deframe_byte(input logic [7:0] b, input logic last);
    result_t     w;
    logic [31:0] fcs;
    // The oldest held byte leaves the delay line and feeds the CRC.
    if (frame_len >= FCS_BYTES) begin
      run_crc = fdc_tb_pkg::fcs_crc_update(run_crc, held[0]);
      if (frame_len - FCS_BYTES >= HEADER_BYTES) begin
        w.kind     = KIND_PAYLOAD;
        w.out_data = held[0];
        w.status   = STATUS_GOOD;  // status field is zero in payload words
        w.is_last  = 1'b0;
        due_q.push_back(w);
      end
    end
    held[0] = held[1];
    held[1] = held[2];
    held[2] = held[3];
    held[3] = b;
    if (frame_len < MAX_FRAME - 1) begin
      frame_len++;
    end
    // On the last byte, judge the frame against the held check field.
    if (last) begin
      fcs        = {held[3], held[2], held[1], held[0]};
      w.kind     = KIND_STATUS;
      w.out_data = 8'h00;
      w.is_last  = 1'b1;
      if (frame_len < HEADER_BYTES + FCS_BYTES) begin
        w.status = STATUS_SHORT;
      end else if (fcs == run_crc) begin
        w.status = STATUS_GOOD;
      end else begin
        w.status = STATUS_MISMATCH;
      end
      due_q.push_back(w);
      clear_frame();
    end
  endtask

  // Count a failed field comparison and report it.
  task automatic field_error(input string what, input int exp_v, input int act_v);
    err_count++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
             $time, what, exp_v, act_v);
  endtask

  // Track accepted bytes and compare each accepted result word.
  always @(posedge clk) begin
    result_t exp_w;
    if (rst) begin
      clear_frame();
      due_q.delete();
    end else begin
      if (rx.valid && rx.ready) begin
        deframe_byte(rx.in_byte, rx.frame_end);
      end
      if (result.valid && result.ready) begin
        if (due_q.size() == 0) begin
          err_count++;
          $display("%0t ns: result word with none due, expected none, actual %0d/%0h/%0d/%0d",
                   $time, result.kind, result.out_data, result.status, result.is_last);
        end else begin
          exp_w = due_q.pop_front();
          if (result.kind !== exp_w.kind) begin
            field_error("kind", exp_w.kind, result.kind);
          end
          if (result.out_data !== exp_w.out_data) begin
            field_error("out_data", exp_w.out_data, result.out_data);
          end
          if (result.status !== exp_w.status) begin
            field_error("status", exp_w.status, result.status);
          end
          if (result.is_last !== exp_w.is_last) begin
            field_error("is_last", exp_w.is_last, result.is_last);
          end
        end
      end
    end
    errors    <= err_count;
    words_due <= due_q.size();
  end

endmodule

FILE: dv/frame_deframer_crc32_check_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the frame deframer: drives framed byte streams with random
// gaps and stalls, and gives the verdict from the checker. Depends on fdc_pkg,
// fdc_tb_pkg, fdc_if, the checker and the RTL.
module frame_deframer_crc32_check_unit_tb;
  import fdc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 1600;
  localparam int DRAIN_CYCLES = 8;
  // A smaller frame limit keeps the saturating frame short; any limit above
  // the longest random frame gives the same words for those frame lengths.
  localparam int TB_MAX_FRAME = 256;

  typedef enum {FRAME_GOOD, FRAME_CORRUPT, FRAME_RANDOM} frame_mix_t;

  logic clk;
  logic rst;
  int   errors;
  int   words_due;
  int   cycles = 0;
  int   sent_words = 0;
  int   sink_hold;

  fdc_byte_if   rx_ch ();
  fdc_result_if res_ch ();

  frame_deframer_crc32_check_unit #(
    .HEADER_BYTES(HEADER_BYTES_DEF),
    .MAX_FRAME   (TB_MAX_FRAME)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .result(res_ch)
  );

  frame_deframer_crc32_check_unit_checker #(
    .HEADER_BYTES(HEADER_BYTES_DEF),
    .MAX_FRAME   (TB_MAX_FRAME)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_ch),
    .result   (res_ch),
    .errors   (errors),
    .words_due(words_due)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 20);
  endfunction

  // Payload length: mostly short, sometimes longer.
  function automatic int payload_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(41, 200);
    end
    return $urandom_range(0, 40);
  endfunction

  // Result side: alternate stretches of ready and stall.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
    end else if (res_ch.ready) begin
      sink_hold = pick_gap();
      if (sink_hold > 0) begin
        res_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        sink_hold = $urandom_range(0, 30);
      end
    end else begin
      res_ch.ready <= 1'b1;
      sink_hold = $urandom_range(0, 30);
    end
  end

  // Offer one byte word and hold it until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic last, input bit burst);
    int   gap;
    logic rdy;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid     <= 1'b1;
    rx_ch.in_byte   <= b;
    rx_ch.frame_end <= last;
    // Ready is sampled away from the edge so the handshake has no race.
    do begin
      @(negedge clk);
      rdy = rx_ch.ready;
      @(posedge clk);
    end while (!rdy);
    sent_words++;
  endtask

  // Build a frame of the given length and send it with the end marker on its last byte.
  task automatic send_frame(input int len, input frame_mix_t mix, input bit burst);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  b;
    logic [31:0] fcs;
    int          pos;
    if (mix == FRAME_RANDOM || len <= FCS_BYTES) begin
      for (int i = 0; i < len; i++) begin
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      // Body followed by its CRC, least significant byte first.
      fcs = CRC_INIT;
      for (int i = 0; i < len - FCS_BYTES; i++) begin
        b = 8'($urandom_range(0, 255));
        frame_bytes.push_back(b);
        fcs = fdc_tb_pkg::fcs_crc_update(fcs, b);
      end
      for (int k = 0; k < FCS_BYTES; k++) begin
        frame_bytes.push_back(fcs[8*k +: 8]);
      end
      // A single flipped bit anywhere in the frame breaks the check.
      if (mix == FRAME_CORRUPT) begin
        pos = $urandom_range(0, len - 1);
        frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < len; i++) begin
      send_word(frame_bytes[i], i == len - 1, burst);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int r;
    bit burst;
    rst             = 1'b1;
    rx_ch.valid     = 1'b0;
    rx_ch.in_byte   = 8'h00;
    rx_ch.frame_end = 1'b0;
    res_ch.ready    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-byte frames at the byte extremes, a frame too short to
    // feed the CRC, and the smallest frame that gets checked.
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_frame(FCS_BYTES, FRAME_RANDOM, 1'b1);
    send_frame(HEADER_BYTES_DEF + FCS_BYTES, FRAME_GOOD, 1'b0);

    // Random frames: mostly well formed, some corrupted, short or noise.
    while (sent_words < RANDOM_WORDS) begin
      r     = $urandom_range(0, 99);
      burst = ($urandom_range(0, 3) == 0);
      if (r < 55) begin
        send_frame(HEADER_BYTES_DEF + FCS_BYTES + payload_len(), FRAME_GOOD, burst);
      end else if (r < 72) begin
        send_frame(HEADER_BYTES_DEF + FCS_BYTES + payload_len(), FRAME_CORRUPT, burst);
      end else if (r < 80) begin
        send_frame($urandom_range(1, HEADER_BYTES_DEF + FCS_BYTES - 1), FRAME_GOOD, burst);
      end else if (r < 90) begin
        send_frame($urandom_range(1, HEADER_BYTES_DEF + FCS_BYTES - 1), FRAME_RANDOM,
                   burst);
      end else begin
        send_frame($urandom_range(1, 60), FRAME_RANDOM, burst);
      end
    end

    // One frame past the byte counter's saturation point.
    send_frame(TB_MAX_FRAME + $urandom_range(0, 16), FRAME_GOOD, 1'b0);
    rx_ch.valid <= 1'b0;

    // Drain the result side, then let the pipeline settle.
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && words_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
